// ----- rtl/core/bic_pkg.sv -----
// ----------------------------------------------------------------------------
// bic_pkg
// Shared types, constants and helper functions of the banked interrupt
// controller.
// ----------------------------------------------------------------------------
package bic_pkg;

  localparam int NUM_BASIC   = 8;
  localparam int NUM_BANK1   = 32;
  localparam int NUM_BANK2   = 32;
  localparam int NUM_SOURCES = NUM_BASIC + NUM_BANK1 + NUM_BANK2;

  localparam int FUNC_W = 2;
  localparam int IRQ_W  = 7;

  localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DISABLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESOLVE = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_RANGE = 1'b1;

  localparam logic [IRQ_W-1:0] BANK1_BASE = IRQ_W'(NUM_BASIC);
  localparam logic [IRQ_W-1:0] BANK2_BASE = IRQ_W'(NUM_BASIC + NUM_BANK1);
  localparam logic [IRQ_W-1:0] SRC_LIMIT  = IRQ_W'(NUM_SOURCES);

  // Sources that have a shortcut bit in the pending word, lowest bit first.
  localparam int SHORT_COUNT = 11;
  localparam int SHORT_IDX_W = 4;
  localparam logic [IRQ_W-1:0] SHORT_SRC [SHORT_COUNT] = '{
    7'd15, 7'd17, 7'd18, 7'd26, 7'd27, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd70
  };

  typedef struct packed {
    logic [NUM_BASIC-1:0] basic;
    logic [NUM_BANK1-1:0] bank1;
    logic [NUM_BANK2-1:0] bank2;
  } mask_set_t;

  typedef struct packed {
    logic             en;
    logic             set;
    logic [IRQ_W-1:0] sel;
  } mask_upd_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [4:0] low_index(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- rtl/core/banked_irq_controller_resolve.sv -----
// Each item is captured in the input register, then its result in the
// result register. Throughput: one item per cycle unless out_ready stalls;
// an input register and a result register form the two stages, and the
// enable masks update as an item leaves stage one.
// Reset clears the enable masks and both stage valid flags.
// ----------------------------------------------------------------------------
// banked_irq_controller_resolve
// Interrupt controller for 72 sources in three banks: enable, disable and
// resolve items, one result per item.
// ----------------------------------------------------------------------------
module banked_irq_controller_resolve (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [6:0]                in_irq_select,
  input  logic [7:0]                in_raw_basic,
  input  logic [31:0]               in_raw_bank1,
  input  logic [31:0]               in_raw_bank2,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [6:0]                out_irq_number,
  output logic                      out_status
);
  import bic_pkg::*;

  logic               s1_valid_r;
  logic [FUNC_W-1:0]  s1_func_r;
  logic [IRQ_W-1:0]   s1_sel_r;
  logic [7:0]         s1_raw_basic_r;
  logic [31:0]        s1_raw_bank1_r;
  logic [31:0]        s1_raw_bank2_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [IRQ_W-1:0]   out_irq_r;
  logic               out_status_r;

  logic               out_found_nxt;
  logic [IRQ_W-1:0]   out_irq_nxt;
  logic               out_status_nxt;

  logic               advance;
  logic               is_access;
  mask_upd_t          upd;
  mask_set_t          masks;
  logic               bad_range;
  logic               pick_found;
  logic [IRQ_W-1:0]   pick_irq;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign is_access = (s1_func_r == FUNC_ENABLE) || (s1_func_r == FUNC_DISABLE);

  assign upd.en  = s1_valid_r && advance && is_access;
  assign upd.set = (s1_func_r == FUNC_ENABLE);
  assign upd.sel = s1_sel_r;

  bic_enable u_enable (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .masks     (masks),
    .bad_range (bad_range)
  );

  bic_pick u_pick (
    .raw_basic  (s1_raw_basic_r),
    .raw_bank1  (s1_raw_bank1_r),
    .raw_bank2  (s1_raw_bank2_r),
    .masks      (masks),
    .found      (pick_found),
    .irq_number (pick_irq)
  );

  always_comb begin
    out_found_nxt  = 1'b0;
    out_irq_nxt    = '0;
    out_status_nxt = STATUS_OK;
    if (s1_func_r == FUNC_RESOLVE) begin
      out_found_nxt = pick_found;
      out_irq_nxt   = pick_irq;
    end else if (is_access && bad_range) begin
      out_status_nxt = STATUS_BAD_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r      <= in_func;
      s1_sel_r       <= in_irq_select;
      s1_raw_basic_r <= in_raw_basic;
      s1_raw_bank1_r <= in_raw_bank1;
      s1_raw_bank2_r <= in_raw_bank2;
    end
    if (advance && s1_valid_r) begin
      out_found_r  <= out_found_nxt;
      out_irq_r    <= out_irq_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_irq_number = out_irq_r;
  assign out_status     = out_status_r;

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_irq_number < SRC_LIMIT)
    else $error("Chosen source number is out of range.");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_irq_number == '0)
    else $error("Source number is nonzero although nothing was found.");

  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_status))
    else $error("A result reports both a found source and a range error.");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_func_r) && $stable(s1_sel_r))
    else $error("Stage one lost its item while the result stage was stalled.");

endmodule

// ----- rtl/core/bic_enable.sv -----
// ----------------------------------------------------------------------------
// bic_enable
// Enable masks of the three source banks, with set and clear by source
// number and the out-of-range check.
// ----------------------------------------------------------------------------
module bic_enable (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bic_pkg::mask_upd_t        upd,
  output bic_pkg::mask_set_t        masks,
  output logic                      bad_range
);
  import bic_pkg::*;

  mask_set_t           masks_r;
  mask_set_t           masks_nxt;
  logic [IRQ_W-1:0]    off1;
  logic [IRQ_W-1:0]    off2;

  assign bad_range = (upd.sel >= SRC_LIMIT);
  assign off1      = upd.sel - BANK1_BASE;
  assign off2      = upd.sel - BANK2_BASE;

  always_comb begin
    masks_nxt = masks_r;
    if (upd.en && !bad_range) begin
      if (upd.sel < BANK1_BASE) begin
        masks_nxt.basic[upd.sel[2:0]] = upd.set;
      end else if (upd.sel < BANK2_BASE) begin
        masks_nxt.bank1[off1[4:0]] = upd.set;
      end else begin
        masks_nxt.bank2[off2[4:0]] = upd.set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r <= '0;
    end else begin
      masks_r <= masks_nxt;
    end
  end

  assign masks = masks_r;

endmodule

// ----- rtl/core/bic_pick.sv -----
// ----------------------------------------------------------------------------
// bic_pick
// Masks the raw source lines and picks one source: basic bank first, then
// shortcut sources, then bank one, then bank two.
// ----------------------------------------------------------------------------
module bic_pick (
  input  logic [7:0]                raw_basic,
  input  logic [31:0]               raw_bank1,
  input  logic [31:0]               raw_bank2,
  input  bic_pkg::mask_set_t        masks,
  output logic                      found,
  output logic [bic_pkg::IRQ_W-1:0] irq_number
);
  import bic_pkg::*;

  logic [NUM_BASIC-1:0]   mb;
  logic [NUM_BANK1-1:0]   m1;
  logic [NUM_BANK2-1:0]   m2;
  logic [NUM_SOURCES-1:0] lines;
  logic [SHORT_COUNT-1:0] short_hit;
  logic [4:0]             short_low;
  logic [4:0]             basic_low;
  logic [4:0]             bank1_low;
  logic [4:0]             bank2_low;

  assign mb    = raw_basic & masks.basic;
  assign m1    = raw_bank1 & masks.bank1;
  assign m2    = raw_bank2 & masks.bank2;
  assign lines = {m2, m1, mb};

  always_comb begin
    for (int k = 0; k < SHORT_COUNT; k++) begin
      short_hit[k] = lines[SHORT_SRC[k]];
    end
  end

  assign basic_low = low_index(32'(mb));
  assign short_low = low_index(32'(short_hit));
  assign bank1_low = low_index(m1);
  assign bank2_low = low_index(m2);

  always_comb begin
    found      = 1'b1;
    irq_number = '0;
    if (mb != '0) begin
      irq_number = IRQ_W'(basic_low[2:0]);
    end else if (short_hit != '0) begin
      irq_number = SHORT_SRC[short_low[SHORT_IDX_W-1:0]];
    end else if (m1 != '0) begin
      irq_number = BANK1_BASE + IRQ_W'(bank1_low);
    end else if (m2 != '0) begin
      irq_number = BANK2_BASE + IRQ_W'(bank2_low);
    end else begin
      found = 1'b0;
    end
  end

endmodule
